>>> sv/dfd_pkg.sv
package dfd_pkg;

    localparam int HDR_BYTES         = 16;
    localparam int POS_W             = 9;
    localparam int QUEUE_DEPTH       = 2;
    localparam int APB_ADDR_W        = 4;
    localparam int APB_DATA_W        = 32;

    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd240;

    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_VERDICT = 1'b1;

    localparam logic [1:0] STATUS_GOOD    = 2'd0;
    localparam logic [1:0] STATUS_CSUM    = 2'd1;
    localparam logic [1:0] STATUS_BAD_END = 2'd2;

    typedef enum logic [1:0] {
        REG_START_MARKER = 2'd0,
        REG_END_MARKER   = 2'd1,
        REG_MAX_PAYLOAD  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] max_payload;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic [1:0]  frame_status;
        logic [15:0] packet_id;
        logic [31:0] timestamp;
        logic [31:0] sequence_number;
        logic [7:0]  payload_length;
    } t_result;

endpackage

>>> sv/dfd_front.sv
module dfd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dfd_pkg::t_cfg   i_cfg,
    input  logic            i_accept,
    input  logic [7:0]      i_rx_byte,
    output logic            o_push,
    output dfd_pkg::t_result o_item
);
    import dfd_pkg::*;

    localparam logic [POS_W-1:0] HDR_POS   = POS_W'(HDR_BYTES);
    localparam logic [POS_W-1:0] HDR_LAST  = POS_W'(HDR_BYTES - 1);
    localparam logic [POS_W-1:0] SEQ_FIRST = POS_W'(2);
    localparam logic [POS_W-1:0] SEQ_LAST  = POS_W'(5);
    localparam logic [POS_W-1:0] TS_FIRST  = POS_W'(8);
    localparam logic [POS_W-1:0] TS_LAST   = POS_W'(11);
    localparam logic [POS_W-1:0] ID_FIRST  = POS_W'(12);
    localparam logic [POS_W-1:0] ID_LAST   = POS_W'(13);
    localparam logic [POS_W-1:0] LEN_FIRST = POS_W'(14);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_len, n_len;
    logic [7:0]       r_sum, n_sum;
    logic [31:0]      r_seq, n_seq;
    logic [31:0]      r_ts, n_ts;
    logic [15:0]      r_id, n_id;
    logic [POS_W-1:0] pay_end;

    assign pay_end = HDR_POS + {1'b0, r_len[7:0]};

    always_comb begin
        n_pos  = r_pos;
        n_len  = r_len;
        n_sum  = r_sum;
        n_seq  = r_seq;
        n_ts   = r_ts;
        n_id   = r_id;
        o_push = 1'b0;
        o_item = '{kind: KIND_PAYLOAD, data_byte: 8'd0, byte_index: 8'd0,
                   frame_status: STATUS_GOOD, packet_id: r_id, timestamp: r_ts,
                   sequence_number: r_seq, payload_length: r_len[7:0]};
        if (i_accept) begin
            if (r_pos == '0) begin
                if (i_rx_byte == i_cfg.start_marker) begin
                    n_pos = POS_W'(1);
                    n_sum = 8'd0;
                end
            end else if (r_pos < HDR_POS) begin
                n_sum = r_sum + i_rx_byte;
                if (r_pos >= SEQ_FIRST && r_pos <= SEQ_LAST) begin
                    n_seq = {i_rx_byte, r_seq[31:8]};
                end else if (r_pos >= TS_FIRST && r_pos <= TS_LAST) begin
                    n_ts = {i_rx_byte, r_ts[31:8]};
                end else if (r_pos >= ID_FIRST && r_pos <= ID_LAST) begin
                    n_id = {i_rx_byte, r_id[15:8]};
                end else if (r_pos >= LEN_FIRST) begin
                    n_len = {i_rx_byte, r_len[15:8]};
                end
                if (r_pos == HDR_LAST && n_len > {8'd0, i_cfg.max_payload}) begin
                    if (i_rx_byte == i_cfg.start_marker) begin
                        n_pos = POS_W'(1);
                        n_sum = 8'd0;
                    end else begin
                        n_pos = '0;
                    end
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end else if (r_pos < pay_end) begin
                n_sum             = r_sum + i_rx_byte;
                o_push            = 1'b1;
                o_item.data_byte  = i_rx_byte;
                o_item.byte_index = 8'(r_pos - HDR_POS);
                n_pos             = r_pos + POS_W'(1);
            end else if (r_pos == pay_end) begin
                n_sum = r_sum - i_rx_byte;
                n_pos = r_pos + POS_W'(1);
            end else begin
                o_push      = 1'b1;
                o_item.kind = KIND_VERDICT;
                if (i_rx_byte != i_cfg.end_marker) begin
                    o_item.frame_status = STATUS_BAD_END;
                end else if (r_sum != 8'd0) begin
                    o_item.frame_status = STATUS_CSUM;
                end else begin
                    o_item.frame_status = STATUS_GOOD;
                end
                n_pos = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_len <= 16'd0;
            r_sum <= 8'd0;
            r_seq <= 32'd0;
            r_ts  <= 32'd0;
            r_id  <= 16'd0;
        end else begin
            r_pos <= n_pos;
            r_len <= n_len;
            r_sum <= n_sum;
            r_seq <= n_seq;
            r_ts  <= n_ts;
            r_id  <= n_id;
        end
    end

endmodule

>>> sv/dfd_queue.sv
module dfd_queue #(
    parameter int DEPTH = dfd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dfd_pkg::t_result i_item,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output dfd_pkg::t_result o_head
);
    import dfd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> sv/dfd_back.sv
module dfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  dfd_pkg::t_result i_head,
    input  logic             i_stall,
    output logic             o_pop,
    output logic             o_valid,
    output dfd_pkg::t_result o_item
);
    import dfd_pkg::*;

    logic    r_valid;
    t_result r_item;

    assign o_pop   = !i_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
    end

endmodule

>>> sv/delimited_frame_deframer_core.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+------------------------------------------------
// rx in    | i_valid / o_stall   | i_rx_byte
// result   | o_valid / i_stall   | o_kind o_data_byte o_byte_index o_frame_status
//          |                     | o_packet_id o_timestamp o_sequence_number
//          |                     | o_payload_length
// config   | psel penable pwrite | paddr pwdata prdata pready
//
// One byte is taken every cycle while o_stall is low; the front tracks frame
// position, header fields and checksum as each byte is accepted.
// A result passes through the result queue and then the output register
// before it shows on o_valid. o_stall rises only when the result queue
// (QUEUE_DEPTH beats) is full behind a stalled output register. Synchronous
// active-low reset; no clearing pass.
module delimited_frame_deframer_core #(
    parameter int QUEUE_DEPTH = dfd_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_kind,
    output logic [7:0]                     o_data_byte,
    output logic [7:0]                     o_byte_index,
    output logic [1:0]                     o_frame_status,
    output logic [15:0]                    o_packet_id,
    output logic [31:0]                    o_timestamp,
    output logic [31:0]                    o_sequence_number,
    output logic [7:0]                     o_payload_length,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dfd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dfd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dfd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import dfd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    logic     accept;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_empty;
    t_result  front_item;
    t_result  head_item;
    t_result  out_item;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker <= 8'd0;
            r_cfg.end_marker   <= 8'd0;
            r_cfg.max_payload  <= MAX_PAYLOAD_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_START_MARKER: r_cfg.start_marker <= pwdata[7:0];
                REG_END_MARKER:   r_cfg.end_marker   <= pwdata[7:0];
                REG_MAX_PAYLOAD:  r_cfg.max_payload  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_START_MARKER: prdata = {24'd0, r_cfg.start_marker};
            REG_END_MARKER:   prdata = {24'd0, r_cfg.end_marker};
            REG_MAX_PAYLOAD:  prdata = {24'd0, r_cfg.max_payload};
            default:          prdata = '0;
        endcase
    end

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    dfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (push),
        .o_item    (front_item)
    );

    dfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_item)
    );

    dfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head_item),
        .i_stall (i_stall),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_item  (out_item)
    );

    assign o_kind            = out_item.kind;
    assign o_data_byte       = out_item.data_byte;
    assign o_byte_index      = out_item.byte_index;
    assign o_frame_status    = out_item.frame_status;
    assign o_packet_id       = out_item.packet_id;
    assign o_timestamp       = out_item.timestamp;
    assign o_sequence_number = out_item.sequence_number;
    assign o_payload_length  = out_item.payload_length;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import dfd_pkg::*;

    localparam int PHASE_BYTES   = 160;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int REG_SPARE     = 3;

    typedef struct {
        logic [7:0] rx;
        bit         lit;
        t_result    want;
    } t_rx_beat;

    typedef struct {
        int          noise;
        logic [31:0] seq;
        logic [31:0] ts;
        logic [15:0] id;
        logic [15:0] len;
        bit          csum_err;
        bit          end_err;
        int          cut;
        bit          lit;
        logic [1:0]  status;
    } t_frame_spec;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [7:0]            i_rx_byte;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_kind;
    logic [7:0]            o_data_byte;
    logic [7:0]            o_byte_index;
    logic [1:0]            o_frame_status;
    logic [15:0]           o_packet_id;
    logic [31:0]           o_timestamp;
    logic [31:0]           o_sequence_number;
    logic [7:0]            o_payload_length;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    delimited_frame_deframer_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_rx_byte         (i_rx_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_kind            (o_kind),
        .o_data_byte       (o_data_byte),
        .o_byte_index      (o_byte_index),
        .o_frame_status    (o_frame_status),
        .o_packet_id       (o_packet_id),
        .o_timestamp       (o_timestamp),
        .o_sequence_number (o_sequence_number),
        .o_payload_length  (o_payload_length),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // deframer shadow state
    t_cfg        cfg      = {8'd0, 8'd0, MAX_PAYLOAD_RESET};
    logic [8:0]  frame_pos = '0;
    logic [15:0] hdr_len   = '0;
    logic [7:0]  run_sum   = '0;
    logic [31:0] seq_acc   = '0;
    logic [31:0] ts_acc    = '0;
    logic [15:0] id_acc    = '0;

    t_rx_beat rx_q[$];
    t_rx_beat cur_beat;
    t_result  deframed_q[$];

    int err_count      = 0;
    int bytes_queued   = 0;
    int bytes_taken    = 0;
    int payload_checked = 0;
    int frames_dropped = 0;
    int verdict_tally [0:3] = '{0, 0, 0, 0};
    bit hold_now = 0;
    bit holding  = 0;

    t_frame_spec directed_frames [0:13] = '{
        '{3, 32'h0000_0000, 32'h0000_0000, 16'h0000, 16'd0,   0, 0, 0, 1, STATUS_GOOD},
        '{0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd0,   0, 0, 0, 1, STATUS_GOOD},
        '{1, 32'h0123_4567, 32'h89AB_CDEF, 16'h1357, 16'd1,   0, 0, 0, 1, STATUS_GOOD},
        '{0, 32'h8000_0001, 32'h7FFF_FFFE, 16'h8001, 16'd240, 0, 0, 0, 1, STATUS_GOOD},
        '{2, 32'h5555_AAAA, 32'h0F0F_F0F0, 16'h00FF, 16'd3,   1, 0, 0, 1, STATUS_CSUM},
        '{0, 32'hAAAA_5555, 32'hF0F0_0F0F, 16'hFF00, 16'd2,   0, 1, 0, 1, STATUS_BAD_END},
        '{0, 32'h1234_5678, 32'h9ABC_DEF0, 16'h4321, 16'd5,   1, 1, 0, 1, STATUS_BAD_END},
        '{0, 32'h0000_0010, 32'h0000_0020, 16'h0030, 16'hFFFF, 0, 0, 0, 0, STATUS_GOOD},
        '{1, 32'h0000_0011, 32'h0000_0021, 16'h0031, 16'h0100, 0, 0, 0, 0, STATUS_GOOD},
        '{0, 32'hCAFE_0002, 32'h0000_0100, 16'h7FFF, 16'd0,   0, 0, 0, 1, STATUS_GOOD},
        '{0, 32'h0000_0012, 32'h0000_0022, 16'h0032, 16'd241, 0, 0, 0, 0, STATUS_GOOD},
        '{0, 32'h0000_0013, 32'h0000_0023, 16'h0033, 16'd4,   0, 0, 0, 0, STATUS_GOOD},
        '{0, 32'h0000_0014, 32'h0000_0024, 16'h0034, 16'd20,  0, 0, 7, 0, STATUS_GOOD},
        '{2, 32'h0000_0015, 32'h0000_0025, 16'h0035, 16'd6,   0, 0, 0, 0, STATUS_GOOD}
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic int draw_wait(inout int left, inout bit calm);
        if (left == 0) begin
            calm = ($urandom_range(0, 2) == 0);
            left = $urandom_range(20, 80);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    task automatic open_on_marker(input logic [7:0] rx);
        if (rx == cfg.start_marker) begin
            frame_pos = 9'd1;
            run_sum   = 8'd0;
        end else begin
            frame_pos = 9'd0;
        end
    endtask

    task automatic deframe_byte(input t_rx_beat bt);
        t_result r;
        bit      emit;
        logic [7:0] rx;
        r    = '0;
        emit = 0;
        rx   = bt.rx;
        if (frame_pos == 0) begin
            open_on_marker(rx);
        end else if (frame_pos < HDR_BYTES) begin
            run_sum = run_sum + rx;
            if (frame_pos >= 2 && frame_pos <= 5)
                seq_acc = {rx, seq_acc[31:8]};
            else if (frame_pos >= 8 && frame_pos <= 11)
                ts_acc = {rx, ts_acc[31:8]};
            else if (frame_pos == 12 || frame_pos == 13)
                id_acc = {rx, id_acc[15:8]};
            else if (frame_pos >= 14)
                hdr_len = {rx, hdr_len[15:8]};
            if (frame_pos == HDR_BYTES - 1 && hdr_len > cfg.max_payload) begin
                frames_dropped++;
                open_on_marker(rx);
            end else begin
                frame_pos = frame_pos + 9'd1;
            end
        end else if (frame_pos < HDR_BYTES + hdr_len) begin
            run_sum = run_sum + rx;
            emit = 1;
            r.kind       = KIND_PAYLOAD;
            r.data_byte  = rx;
            r.byte_index = 8'(frame_pos - HDR_BYTES);
            frame_pos = frame_pos + 9'd1;
        end else if (frame_pos == HDR_BYTES + hdr_len) begin
            run_sum = run_sum - rx;
            frame_pos = frame_pos + 9'd1;
        end else begin
            emit = 1;
            r.kind = KIND_VERDICT;
            if (rx != cfg.end_marker)
                r.frame_status = STATUS_BAD_END;
            else if (run_sum != 8'd0)
                r.frame_status = STATUS_CSUM;
            else
                r.frame_status = STATUS_GOOD;
            frame_pos = 9'd0;
        end
        if (emit) begin
            r.packet_id       = id_acc;
            r.timestamp       = ts_acc;
            r.sequence_number = seq_acc;
            r.payload_length  = hdr_len[7:0];
            deframed_q.push_back(bt.lit ? bt.want : r);
        end
    endtask

    task automatic queue_frame(input t_frame_spec f);
        logic [7:0] fb[$];
        logic [7:0] v;
        logic [7:0] sum;
        t_rx_beat   bt;
        bit         dropped;
        int         k;
        int         total;
        bt.lit  = 0;
        bt.want = '0;
        for (k = 0; k < f.noise; k++) begin
            v = 8'($urandom_range(0, 255));
            if (v == cfg.start_marker)
                v = ~v;
            bt.rx = v;
            rx_q.push_back(bt);
            bytes_queued++;
        end
        fb.push_back(cfg.start_marker);
        fb.push_back(8'($urandom_range(0, 255)));
        for (k = 0; k < 4; k++) fb.push_back(f.seq[8*k +: 8]);
        fb.push_back(8'($urandom_range(0, 255)));
        fb.push_back(8'($urandom_range(0, 255)));
        for (k = 0; k < 4; k++) fb.push_back(f.ts[8*k +: 8]);
        fb.push_back(f.id[7:0]);
        fb.push_back(f.id[15:8]);
        fb.push_back(f.len[7:0]);
        fb.push_back(f.len[15:8]);
        dropped = f.len > cfg.max_payload;
        if (!dropped) begin
            for (k = 0; k < f.len; k++) fb.push_back(8'($urandom_range(0, 255)));
            sum = 8'd0;
            for (k = 1; k < fb.size(); k++) sum = sum + fb[k];
            fb.push_back(sum + 8'(f.csum_err));
            v = cfg.end_marker;
            if (f.end_err)
                v = v ^ 8'($urandom_range(1, 255));
            fb.push_back(v);
        end
        total = (f.cut > 0 && f.cut < fb.size()) ? f.cut : fb.size();
        for (k = 0; k < total; k++) begin
            bt.rx  = fb[k];
            bt.lit = f.lit && !dropped && (k == fb.size() - 1);
            bt.want = '{kind: KIND_VERDICT, data_byte: 8'd0, byte_index: 8'd0,
                        frame_status: f.status, packet_id: f.id, timestamp: f.ts,
                        sequence_number: f.seq, payload_length: f.len[7:0]};
            rx_q.push_back(bt);
            bytes_queued++;
        end
    endtask

    task automatic apb_write(input int idx, input logic [7:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * idx);
        pwdata  <= {24'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START_MARKER: cfg.start_marker = value;
            REG_END_MARKER:   cfg.end_marker   = value;
            REG_MAX_PAYLOAD:  cfg.max_payload  = value;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (rx_q.size() != 0 || bytes_taken != bytes_queued || deframed_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    initial begin : rx_source
        t_rx_beat bt;
        int       gap;
        int       left;
        bit       calm;
        left = 0;
        calm = 0;
        i_valid   <= 1'b0;
        i_rx_byte <= 8'd0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_q.size() == 0) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end else begin
                bt  = rx_q.pop_front();
                gap = draw_wait(left, calm);
                if (holding)
                    gap = 0;
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                i_valid   <= 1'b1;
                i_rx_byte <= bt.rx;
                cur_beat  <= bt;
                @(posedge i_clk);
                while (o_stall) @(posedge i_clk);
            end
        end
    end

    initial begin : result_sink
        int n;
        int left;
        bit calm;
        left = 0;
        calm = 0;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_now) begin
                // hold off long enough for the result queue to back up into o_stall
                hold_now = 0;
                holding  = 1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
                holding  = 0;
            end else if (o_valid && !i_stall) begin
                n = draw_wait(left, calm);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                bytes_taken++;
                deframe_byte(cur_beat);
            end
            if (o_valid && !i_stall) begin
                got = {o_kind, o_data_byte, o_byte_index, o_frame_status, o_packet_id,
                       o_timestamp, o_sequence_number, o_payload_length};
                if (deframed_q.size() == 0) begin
                    $display("%0t: result with nothing expected, got kind %0h data %0h status %0h",
                             $time, o_kind, o_data_byte, o_frame_status);
                    err_count++;
                end else begin
                    want = deframed_q.pop_front();
                    check_field("kind", 32'(want.kind), 32'(got.kind));
                    check_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
                    check_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
                    check_field("frame_status", 32'(want.frame_status),
                                32'(got.frame_status));
                    check_field("packet_id", 32'(want.packet_id), 32'(got.packet_id));
                    check_field("timestamp", want.timestamp, got.timestamp);
                    check_field("sequence_number", want.sequence_number, got.sequence_number);
                    check_field("payload_length", 32'(want.payload_length),
                                32'(got.payload_length));
                    if (want.kind == KIND_VERDICT)
                        verdict_tally[want.frame_status]++;
                    else
                        payload_checked++;
                end
            end
        end
    end

    initial begin : stimulus
        t_frame_spec f;
        t_cfg        plan [0:3];
        int          ph;
        int          k;
        int          phase_end;
        int          lim;
        int          pick;
        i_rst_n   <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        plan[0] = {8'hA5, 8'h5A, 8'd240};
        plan[1] = {8'hFF, 8'h00, 8'd0};
        plan[2] = {8'h00, 8'hFF, 8'd255};
        plan[3] = 24'($urandom);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < $size(directed_frames); k++)
            queue_frame(directed_frames[k]);
        wait_idle();

        for (ph = 0; ph < 4; ph++) begin
            apb_write(REG_START_MARKER, plan[ph].start_marker);
            apb_write(REG_END_MARKER, plan[ph].end_marker);
            apb_write(REG_MAX_PAYLOAD, plan[ph].max_payload);
            if (ph == 1)
                apb_write(REG_SPARE, 8'($urandom));
            phase_end = bytes_queued + PHASE_BYTES;
            while (bytes_queued < phase_end) begin
                f.noise = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 4);
                f.seq   = $urandom;
                f.ts    = $urandom;
                f.id    = 16'($urandom);
                lim  = (cfg.max_payload < 12) ? cfg.max_payload : 12;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    f.len = 16'($urandom_range(0, lim));
                else if (pick < 88)
                    f.len = 16'($urandom_range(0, cfg.max_payload));
                else if (pick < 93)
                    f.len = 16'(cfg.max_payload);
                else if (pick < 97)
                    f.len = cfg.max_payload + 16'd1;
                else
                    f.len = 16'($urandom_range(cfg.max_payload + 1, 65535));
                f.csum_err = ($urandom_range(0, 7) == 0);
                f.end_err  = ($urandom_range(0, 7) == 0);
                f.cut      = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 17 + f.len) : 0;
                f.lit      = 0;
                f.status   = STATUS_GOOD;
                queue_frame(f);
            end
            if (ph == 0)
                hold_now = 1;
            wait_idle();
        end

        $display("tb: %0d bytes fed over %0d register settings, %0d payload beats checked",
                 bytes_taken, 5, payload_checked);
        $display("tb: verdicts good %0d, checksum %0d, end marker %0d; %0d frames dropped on length",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2], frames_dropped);
        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
